FILE: design/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
package qrs_pkg;

	localparam int CW       = 16;
	localparam int RW       = 32;
	localparam int RF       = 16;
	localparam int SE       = 14;
	localparam int DW       = 2 * CW + 2;
	localparam int SQ_STEPS = (DW - 1 + 2 * SE + 1) / 2;
	localparam int RADW     = 2 * SQ_STEPS;
	localparam int REM_W    = SQ_STEPS + 4;
	localparam int BW       = CW + SE + 1;
	localparam int NMW      = SQ_STEPS + 2;
	localparam int SW       = NMW + 1;
	localparam int SH       = RF - SE - 1;
	localparam int XW       = NMW + RW;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_AZERO = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;

	typedef struct packed {
		logic signed [CW-1:0] coef_a;
		logic signed [CW-1:0] coef_b;
		logic signed [CW-1:0] coef_c;
	} in_t;

	typedef struct packed {
		logic [1:0]           root_count;
		logic signed [RW-1:0] first_root;
		logic signed [RW-1:0] second_root;
		logic [1:0]           status;
	} out_t;

	typedef struct packed {
		logic                 azero;
		logic                 dneg;
		logic                 dzero;
		logic                 aneg;
		logic [CW-1:0]        amag;
		logic signed [BW-1:0] base;
	} meta_t;

	typedef struct packed {
		logic [RADW-1:0]     rad;
		logic [REM_W-1:0]    rem;
		logic [SQ_STEPS-1:0] root;
		meta_t               meta;
	} sqrt_t;

	typedef struct packed {
		logic [NMW-1:0] num_p;
		logic [NMW-1:0] num_m;
		logic [CW-1:0]  rem_p;
		logic [CW-1:0]  rem_m;
		logic           neg_p;
		logic           neg_m;
		meta_t          meta;
	} div_t;

endpackage

FILE: design/quadratic_root_solver.sv
// Quadratic root solver: pipelined discriminant, square root and dividers.
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+------------------------
//  coef     | coef_valid  | coef_stall  | coef  (in_t)
//  root     | root_valid  | root_stall  | roots (out_t)
//
// One item enters per cycle while the output is not stalled; the pipeline depth
// is set by the one-bit-per-stage square root and dividers.
// Reset clears all valid bits. A stalled output with a valid result holds
// every stage, so coef_stall follows root_stall while the output is full.
module quadratic_root_solver
	import qrs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic coef_valid,
	output logic coef_stall,
	input  in_t  coef,
	output logic root_valid,
	input  logic root_stall,
	output out_t roots
);

	logic adv;

	logic signed [2*CW-1:0] bb_s1, ac_s1;
	meta_t                  meta_s1;
	logic                   v_s1;

	sqrt_t sq_s [0:SQ_STEPS];
	logic  vsq_s [0:SQ_STEPS];
	sqrt_t sq_n [1:SQ_STEPS];

	div_t  dv_s [0:NMW];
	logic  vdv_s [0:NMW];
	div_t  dv_n [1:NMW];

	out_t  out_q;
	logic  vout_q;

	logic signed [DW-1:0] disc;
	sqrt_t                sq_first;
	div_t                 dv_first;
	logic signed [SW-1:0] sp, sm, ap, am;
	logic [RW:0]          cl_p, cl_m;
	out_t                 res;

	assign adv        = !vout_q || !root_stall;
	assign coef_stall = !adv;
	assign root_valid = vout_q;
	assign roots      = out_q;

	function automatic logic [RW:0] clamp(input logic [NMW-1:0] q, input logic neg);
		logic [XW-1:0] qx, maxp;
		logic [RW-1:0] v;
		logic          s;
		qx   = XW'(q);
		maxp = XW'({1'b0, {(RW-1){1'b1}}});
		s    = 1'b0;
		v    = q[RW-1:0];
		if (!neg) begin
			if (qx > maxp) begin
				s = 1'b1;
				v = maxp[RW-1:0];
			end
		end else begin
			if (qx > maxp + XW'(1)) begin
				s = 1'b1;
				v = {1'b1, {(RW-1){1'b0}}};
			end else begin
				v = RW'(-qx);
			end
		end
		return {s, v};
	endfunction

	// discriminant and square root seed
	always_comb begin
		disc = DW'(bb_s1) - (DW'(ac_s1) <<< 2);
		sq_first            = '0;
		sq_first.meta       = meta_s1;
		sq_first.meta.dneg  = disc[DW-1];
		sq_first.meta.dzero = (disc == '0);
		sq_first.rad        = RADW'({disc[DW-2:0], {(2*SE){1'b0}}});
	end

	// square root steps
	always_comb begin
		logic [REM_W-1:0] rsh, trial;
		for (int k = 1; k <= SQ_STEPS; k++) begin
			sq_n[k]     = sq_s[k-1];
			rsh         = {sq_s[k-1].rem[REM_W-3:0], sq_s[k-1].rad[RADW-1 -: 2]};
			trial       = REM_W'({sq_s[k-1].root, 2'b01});
			sq_n[k].rad = {sq_s[k-1].rad[RADW-3:0], 2'b00};
			if (rsh >= trial) begin
				sq_n[k].rem  = rsh - trial;
				sq_n[k].root = {sq_s[k-1].root[SQ_STEPS-2:0], 1'b1};
			end else begin
				sq_n[k].rem  = rsh;
				sq_n[k].root = {sq_s[k-1].root[SQ_STEPS-2:0], 1'b0};
			end
		end
	end

	// numerators
	always_comb begin
		sp = SW'(sq_s[SQ_STEPS].meta.base) + SW'({1'b0, sq_s[SQ_STEPS].root});
		sm = SW'(sq_s[SQ_STEPS].meta.base) - SW'({1'b0, sq_s[SQ_STEPS].root});
		ap = sp[SW-1] ? -sp : sp;
		am = sm[SW-1] ? -sm : sm;
		dv_first       = '0;
		dv_first.meta  = sq_s[SQ_STEPS].meta;
		dv_first.num_p = NMW'(ap) << SH;
		dv_first.num_m = NMW'(am) << SH;
		dv_first.neg_p = sp[SW-1] ^ sq_s[SQ_STEPS].meta.aneg;
		dv_first.neg_m = sm[SW-1] ^ sq_s[SQ_STEPS].meta.aneg;
	end

	// divider steps
	always_comb begin
		logic [CW:0] rp, rm, dv;
		for (int k = 1; k <= NMW; k++) begin
			dv_n[k] = dv_s[k-1];
			dv      = {1'b0, dv_s[k-1].meta.amag};
			rp      = {dv_s[k-1].rem_p, dv_s[k-1].num_p[NMW-1]};
			rm      = {dv_s[k-1].rem_m, dv_s[k-1].num_m[NMW-1]};
			if (rp >= dv) begin
				dv_n[k].rem_p = CW'(rp - dv);
				dv_n[k].num_p = {dv_s[k-1].num_p[NMW-2:0], 1'b1};
			end else begin
				dv_n[k].rem_p = rp[CW-1:0];
				dv_n[k].num_p = {dv_s[k-1].num_p[NMW-2:0], 1'b0};
			end
			if (rm >= dv) begin
				dv_n[k].rem_m = CW'(rm - dv);
				dv_n[k].num_m = {dv_s[k-1].num_m[NMW-2:0], 1'b1};
			end else begin
				dv_n[k].rem_m = rm[CW-1:0];
				dv_n[k].num_m = {dv_s[k-1].num_m[NMW-2:0], 1'b0};
			end
		end
	end

	// saturate and assemble
	always_comb begin
		cl_p = clamp(dv_s[NMW].num_p, dv_s[NMW].neg_p);
		cl_m = clamp(dv_s[NMW].num_m, dv_s[NMW].neg_m);
		res  = '0;
		if (dv_s[NMW].meta.azero) begin
			res.status = ST_AZERO;
		end else if (!dv_s[NMW].meta.dneg) begin
			res.first_root = cl_p[RW-1:0];
			if (dv_s[NMW].meta.dzero) begin
				res.root_count  = 2'd1;
				res.second_root = cl_p[RW-1:0];
				res.status      = cl_p[RW] ? ST_SAT : ST_OK;
			end else begin
				res.root_count  = 2'd2;
				res.second_root = cl_m[RW-1:0];
				res.status      = (cl_p[RW] || cl_m[RW]) ? ST_SAT : ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			vout_q <= 1'b0;
			for (int k = 0; k <= SQ_STEPS; k++) vsq_s[k] <= 1'b0;
			for (int k = 0; k <= NMW; k++) vdv_s[k] <= 1'b0;
		end else if (adv) begin
			v_s1     <= coef_valid;
			vsq_s[0] <= v_s1;
			for (int k = 1; k <= SQ_STEPS; k++) vsq_s[k] <= vsq_s[k-1];
			vdv_s[0] <= vsq_s[SQ_STEPS];
			for (int k = 1; k <= NMW; k++) vdv_s[k] <= vdv_s[k-1];
			vout_q   <= vdv_s[NMW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bb_s1          <= (2*CW)'(coef.coef_b) * (2*CW)'(coef.coef_b);
			ac_s1          <= (2*CW)'(coef.coef_a) * (2*CW)'(coef.coef_c);
			meta_s1.azero  <= (coef.coef_a == '0);
			meta_s1.dneg   <= 1'b0;
			meta_s1.dzero  <= 1'b0;
			meta_s1.aneg   <= coef.coef_a[CW-1];
			meta_s1.amag   <= coef.coef_a[CW-1] ? CW'(-coef.coef_a) : coef.coef_a;
			meta_s1.base   <= -(BW'(coef.coef_b) <<< SE);
			sq_s[0]        <= sq_first;
			for (int k = 1; k <= SQ_STEPS; k++) sq_s[k] <= sq_n[k];
			dv_s[0]        <= dv_first;
			for (int k = 1; k <= NMW; k++) dv_s[k] <= dv_n[k];
			out_q          <= res;
		end
	end

endmodule
